>>> design/fdpc_pkg.sv
// Shared types, constants and membership tables for the fuzzy distance PWM controller.
package fdpc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MW        = FRAC_BITS + 1;
  localparam int TAB_BITS  = 24;
  localparam int SHIFT     = TAB_BITS - FRAC_BITS;
  localparam int TAB_N     = 23;

  typedef logic [MW-1:0] memb_t;
  typedef memb_t memb_tab_t [TAB_N];

  localparam memb_t ONE = memb_t'(1) << FRAC_BITS;

  localparam logic [12:0] DIV_NUMER = 13'd6050;
  localparam logic [6:0]  DIST_MIN  = 7'd10;
  localparam logic [6:0]  DIST_MAX  = 7'd80;

  localparam logic [23:0] EXP_TENTH [9] = '{
    24'd15180653, 24'd13736023, 24'd11246104, 24'd7538489, 24'd3387261,
    24'd683876, 24'd27876, 24'd46, 24'd0
  };
  localparam logic [23:0] EXP_FACT [9] = '{
    24'd15943031, 24'd15150322, 24'd13681188, 24'd11156494, 24'd7418833,
    24'd3280585, 24'd641479, 24'd24527, 24'd36
  };

  function automatic memb_tab_t build_tab(input logic sel);
    memb_tab_t t;
    longint unsigned r;
    int unsigned s;
    for (int m = 0; m < TAB_N; m++) begin
      s = m * m;
      r = longint'(1) << TAB_BITS;
      for (int i = 0; i < 9; i++) begin
        if (s[i]) begin
          r = (r * (sel ? EXP_FACT[i] : EXP_TENTH[i]) + (longint'(1) << (TAB_BITS - 1)))
              >> TAB_BITS;
        end
      end
      if (SHIFT > 0) r = (r + (longint'(1) << (SHIFT - 1))) >> SHIFT;
      t[m] = memb_t'(r);
    end
    return t;
  endfunction

  localparam memb_tab_t BELL_TAB = build_tab(1'b0);
  localparam memb_tab_t FACT_TAB = build_tab(1'b1);

  function automatic memb_t bell(input logic [7:0] mag);
    return (mag < 8'(TAB_N)) ? BELL_TAB[mag[4:0]] : '0;
  endfunction

  function automatic memb_t fact_of(input logic [7:0] mag);
    return (mag < 8'(TAB_N)) ? FACT_TAB[mag[4:0]] : '0;
  endfunction

  typedef struct packed {
    logic [6:0] dist_cm;
    logic       zero;
    memb_t      a1;
    memb_t      a2;
    memb_t      a3;
    memb_t      neg;
    memb_t      cen;
    memb_t      pos;
    memb_t      fact;
  } mid_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_ACC, B_PREP, B_DIV, B_OUT} back_state_t;

  typedef enum logic [1:0] {
    REG_SETPOINT = 2'd0, REG_CLOW = 2'd1, REG_CMID = 2'd2, REG_CHIGH = 2'd3
  } reg_idx_t;

endpackage

>>> design/fdpc_front.sv
// Front end: reading to distance divider and membership grading.
module fdpc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        adc_high,
  input  logic [7:0]        adc_low,
  input  logic [6:0]        setpoint_cm,
  output logic              mid_push,
  input  logic              mid_full,
  output fdpc_pkg::mid_t    mid_item
);

  fdpc_pkg::front_state_t state, state_next;
  logic [15:0] rdg;
  logic [16:0] rem;
  logic [12:0] quo;
  logic [3:0]  cnt;
  logic [6:0]  dist_cm;
  logic        zero;

  logic [15:0] reading;
  logic [16:0] rem_sh;
  logic        ge;
  logic [12:0] quo_new;
  logic [12:0] qm;
  logic [6:0]  dist_new;

  assign reading = {adc_high, adc_low};
  assign rem_sh  = {rem[15:0], quo[12]};
  assign ge      = rem_sh >= {1'b0, rdg};
  assign quo_new = {quo[11:0], ge};
  assign qm      = (quo_new >= 13'd2) ? quo_new - 13'd2 : quo_new;
  assign dist_new = (qm < 13'(fdpc_pkg::DIST_MIN)) ? fdpc_pkg::DIST_MIN :
                    (qm > 13'(fdpc_pkg::DIST_MAX)) ? fdpc_pkg::DIST_MAX : qm[6:0];

  always_comb begin
    state_next = state;
    case (state)
      fdpc_pkg::F_IDLE: if (push) state_next = (reading == '0) ? fdpc_pkg::F_PUSH
                                                                : fdpc_pkg::F_DIV;
      fdpc_pkg::F_DIV:  if (cnt == '0) state_next = fdpc_pkg::F_PUSH;
      fdpc_pkg::F_PUSH: if (!mid_full) state_next = fdpc_pkg::F_IDLE;
      default:          state_next = fdpc_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    full     = (state != fdpc_pkg::F_IDLE);
    mid_push = (state == fdpc_pkg::F_PUSH) && !mid_full;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= fdpc_pkg::F_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      fdpc_pkg::F_IDLE: begin
        if (push) begin
          rdg     <= reading;
          rem     <= '0;
          quo     <= fdpc_pkg::DIV_NUMER;
          cnt     <= 4'd12;
          zero    <= (reading == '0);
          dist_cm <= fdpc_pkg::DIST_MAX;
        end
      end
      fdpc_pkg::F_DIV: begin
        rem <= ge ? rem_sh - {1'b0, rdg} : rem_sh;
        quo <= quo_new;
        cnt <= cnt - 4'd1;
        if (cnt == '0) dist_cm <= dist_new;
      end
      default: ;
    endcase
  end

  // membership grades from the registered distance
  logic signed [8:0] e;
  logic [7:0] d8;
  logic [7:0] dmag20;
  logic [7:0] emag;

  always_comb begin
    d8     = {1'b0, dist_cm};
    e      = $signed({2'b0, setpoint_cm}) - $signed({2'b0, dist_cm});
    dmag20 = (d8 >= 8'd20) ? d8 - 8'd20 : 8'd20 - d8;
    emag   = e[8] ? 8'(-e) : e[7:0];
    mid_item.dist_cm = dist_cm;
    mid_item.zero = zero;
    mid_item.a1   = (d8 < 8'd18) ? fdpc_pkg::ONE - fdpc_pkg::bell(8'd18 - d8) : '0;
    mid_item.a2   = fdpc_pkg::bell(dmag20);
    mid_item.a3   = (d8 > 8'd22) ? fdpc_pkg::ONE - fdpc_pkg::bell(d8 - 8'd22) : '0;
    mid_item.neg  = (e < -9'sd2) ? fdpc_pkg::ONE - fdpc_pkg::bell(emag - 8'd2) : '0;
    mid_item.cen  = fdpc_pkg::bell(emag);
    mid_item.pos  = (e > 9'sd2) ? fdpc_pkg::ONE - fdpc_pkg::bell(emag - 8'd2) : '0;
    mid_item.fact = fdpc_pkg::fact_of(dmag20);
  end

endmodule

>>> design/fdpc_queue.sv
// Two-entry queue between the front and back ends.
module fdpc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  fdpc_pkg::mid_t wdata,
  input  logic           pop,
  output logic           empty,
  output fdpc_pkg::mid_t rdata
);

  fdpc_pkg::mid_t mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push && !full) wptr <= !wptr;
      if (pop && !empty) rptr <= !rptr;
      count <= count + 2'((push && !full)) - 2'((pop && !empty));
    end
  end

endmodule

>>> design/fdpc_back.sv
// Back end: rule clipping, weighted sum and defuzzifying divide.
module fdpc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  output logic           q_pop,
  input  fdpc_pkg::mid_t q_item,
  input  logic [8:0]     centre_low,
  input  logic [8:0]     centre_mid,
  input  logic [8:0]     centre_high,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     duty,
  output logic [6:0]     distance_cm,
  output logic           zero_reading
);

  fdpc_pkg::back_state_t state, state_next;
  fdpc_pkg::memb_t w [7];
  fdpc_pkg::memb_t w_new [7];
  logic [2:0]  cnt;
  logic [27:0] num;
  logic [18:0] den;
  logic [27:0] rem;
  logic [27:0] dsh;
  logic [8:0]  q;
  logic [3:0]  dcnt;
  logic [6:0]  dist_cm;
  logic        zero;
  logic        out_valid;
  logic [8:0]  centre;
  logic        ge;

  function automatic fdpc_pkg::memb_t mn(input fdpc_pkg::memb_t a, input fdpc_pkg::memb_t b);
    return (a < b) ? a : b;
  endfunction

  always_comb begin
    w_new[0] = mn(mn(q_item.a1, q_item.cen), q_item.fact);
    w_new[1] = mn(mn(q_item.a1, q_item.pos), q_item.fact);
    w_new[2] = mn(mn(q_item.a2, q_item.neg), q_item.fact);
    w_new[3] = mn(mn(q_item.a2, q_item.cen), q_item.fact);
    w_new[4] = mn(mn(q_item.a2, q_item.pos), q_item.fact);
    w_new[5] = mn(mn(q_item.a3, q_item.neg), q_item.fact);
    w_new[6] = mn(mn(q_item.a3, q_item.cen), q_item.fact);
  end

  always_comb begin
    case (cnt)
      3'd0, 3'd1:       centre = centre_low;
      3'd2, 3'd3, 3'd4: centre = centre_mid;
      default:          centre = centre_high;
    endcase
  end

  assign ge = rem >= dsh;

  always_comb begin
    state_next = state;
    case (state)
      fdpc_pkg::B_IDLE: if (!q_empty) state_next = fdpc_pkg::B_ACC;
      fdpc_pkg::B_ACC:  if (cnt == 3'd6) state_next = fdpc_pkg::B_PREP;
      fdpc_pkg::B_PREP: state_next = fdpc_pkg::B_DIV;
      fdpc_pkg::B_DIV:  if (dcnt == '0) state_next = fdpc_pkg::B_OUT;
      fdpc_pkg::B_OUT:  if (!out_valid) state_next = fdpc_pkg::B_IDLE;
      default:          state_next = fdpc_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == fdpc_pkg::B_IDLE) && !q_empty;
    empty = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fdpc_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == fdpc_pkg::B_OUT && !out_valid) out_valid <= 1'b1;
      else if (pop && out_valid) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      fdpc_pkg::B_IDLE: begin
        if (!q_empty) begin
          w       <= w_new;
          dist_cm <= q_item.dist_cm;
          zero    <= q_item.zero;
          cnt     <= '0;
          num     <= '0;
          den     <= '0;
        end
      end
      fdpc_pkg::B_ACC: begin
        num <= num + 28'(w[cnt] * centre);
        den <= den + 19'(w[cnt]);
        cnt <= cnt + 3'd1;
      end
      fdpc_pkg::B_PREP: begin
        rem  <= num;
        dsh  <= {1'b0, den, 8'b0};
        q    <= '0;
        dcnt <= 4'd8;
      end
      fdpc_pkg::B_DIV: begin
        if (ge) rem <= rem - dsh;
        q    <= {q[7:0], ge};
        dsh  <= dsh >> 1;
        dcnt <= dcnt - 4'd1;
      end
      fdpc_pkg::B_OUT: begin
        if (!out_valid) begin
          duty         <= (den == '0) ? 8'd0 : (q > 9'd255) ? 8'd255 : q[7:0];
          distance_cm  <= dist_cm;
          zero_reading <= zero;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> design/fuzzy_distance_pwm_controller.sv
// Top level of the fuzzy distance PWM controller: registers, front, queue and back.
//
//  channel   handshake           payload
//  input     push / full         adc_high, adc_low
//  result    pop / empty         duty, distance_cm, zero_reading
//  config    wr_en               wr_index, wr_data
//
// Front end divides each reading in a 13-step restoring divider; a zero reading skips it.
// Back end runs 7 multiply-accumulate steps, then 9 divide steps, for each item.
// Sustained throughput is set by the back end; neither end takes a new item while busy.
// A two-entry queue parts the two ends; a waiting result stalls the back end.
// Reset is synchronous; it clears control state and sets config registers to defaults.
module fuzzy_distance_pwm_controller (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] adc_high,
  input  logic [7:0] adc_low,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] duty,
  output logic [6:0] distance_cm,
  output logic       zero_reading,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [8:0] wr_data
);

  logic [6:0] setpoint_cm;
  logic [8:0] centre_low, centre_mid, centre_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_cm <= 7'd19;
      centre_low  <= 9'd245;
      centre_mid  <= 9'd252;
      centre_high <= 9'd256;
    end else if (wr_en) begin
      case (fdpc_pkg::reg_idx_t'(wr_index))
        fdpc_pkg::REG_SETPOINT: setpoint_cm <= wr_data[6:0];
        fdpc_pkg::REG_CLOW:     centre_low  <= wr_data;
        fdpc_pkg::REG_CMID:     centre_mid  <= wr_data;
        fdpc_pkg::REG_CHIGH:    centre_high <= wr_data;
        default: ;
      endcase
    end
  end

  fdpc_pkg::mid_t mid_in, mid_out;
  logic mid_push, mid_full, mid_pop, mid_empty;

  fdpc_front u_front (
    .clk, .rst, .push, .full, .adc_high, .adc_low, .setpoint_cm,
    .mid_push, .mid_full, .mid_item(mid_in)
  );

  fdpc_queue u_queue (
    .clk, .rst, .push(mid_push), .full(mid_full), .wdata(mid_in),
    .pop(mid_pop), .empty(mid_empty), .rdata(mid_out)
  );

  fdpc_back u_back (
    .clk, .rst, .q_empty(mid_empty), .q_pop(mid_pop), .q_item(mid_out),
    .centre_low, .centre_mid, .centre_high,
    .pop, .empty, .duty, .distance_cm, .zero_reading
  );

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (distance_cm >= 7'd10 && distance_cm <= 7'd80))
    else $error("distance out of range");

  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    (!empty && zero_reading) |-> distance_cm == 7'd80)
    else $error("zero reading without saturated distance");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result dropped before pop");

  a_queue_flow: assert property (@(posedge clk) disable iff (rst)
    (mid_full && !mid_pop) |=> mid_full)
    else $error("queue lost an entry");

endmodule

>>> verif/tb_fuzzy_distance_pwm_controller.sv
// Self-checking testbench for the fuzzy distance PWM controller.
`timescale 1ns / 100ps

class duty_scoreboard;
  logic [6:0] setpoint;
  logic [8:0] c_low, c_mid, c_high;
  logic [7:0] exp_duty[$];
  logic [6:0] exp_dist[$];
  logic       exp_zero[$];
  int         errors;

  function new();
    setpoint = 7'd19; c_low = 9'd245; c_mid = 9'd252; c_high = 9'd256;
    errors = 0;
  endfunction

  function longint unsigned gauss(int unsigned s, bit fact);
    longint unsigned tenth[9] = '{15180653, 13736023, 11246104, 7538489, 3387261,
                                  683876, 27876, 46, 0};
    longint unsigned ftab[9] = '{15943031, 15150322, 13681188, 11156494, 7418833,
                                 3280585, 641479, 24527, 36};
    longint unsigned r;
    r = 64'd1 << 24;
    if (s >= 512) return 0;
    for (int i = 0; i < 9; i++)
      if (s[i]) r = (r * (fact ? ftab[i] : tenth[i]) + (64'd1 << 23)) >> 24;
    return (r + 128) >> 8;
  endfunction

  function int unsigned sq(int a, int b);
    int d;
    d = a - b;
    return d * d;
  endfunction

  function longint unsigned below(int x, int c);
    if (x >= c) return 0;
    return 65536 - gauss(sq(x, c), 0);
  endfunction

  function longint unsigned above(int x, int c);
    if (x <= c) return 0;
    return 65536 - gauss(sq(x, c), 0);
  endfunction

  function longint unsigned mn(longint unsigned a, longint unsigned b);
    return a < b ? a : b;
  endfunction

  function void note_reading(logic [7:0] hi, logic [7:0] lo);
    int unsigned rd, dist_cm;
    int d, e;
    longint unsigned a1, a2, a3, ng, cn, ps, ft, w, num, den, dy;
    longint unsigned g[7];
    longint unsigned c[7];
    bit z;
    rd = {hi, lo};
    z = (rd == 0);
    if (z) dist_cm = 80;
    else begin
      dist_cm = 6050 / rd;
      if (dist_cm >= 2) dist_cm -= 2;
      if (dist_cm < 10) dist_cm = 10;
      if (dist_cm > 80) dist_cm = 80;
    end
    d = dist_cm;
    e = int'(setpoint) - d;
    a1 = below(d, 18); a2 = gauss(sq(d, 20), 0); a3 = above(d, 22);
    ng = below(e, -2); cn = gauss(sq(e, 0), 0); ps = above(e, 2);
    ft = gauss(sq(d, 20), 1);
    g[0] = mn(a1, cn); g[1] = mn(a1, ps); g[2] = mn(a2, ng); g[3] = mn(a2, cn);
    g[4] = mn(a2, ps); g[5] = mn(a3, ng); g[6] = mn(a3, cn);
    c[0] = c_low; c[1] = c_low; c[2] = c_mid; c[3] = c_mid; c[4] = c_mid;
    c[5] = c_high; c[6] = c_high;
    num = 0; den = 0; dy = 0;
    for (int k = 0; k < 7; k++) begin
      w = mn(g[k], ft);
      num += w * c[k];
      den += w;
    end
    if (den != 0) begin
      dy = num / den;
      if (dy > 255) dy = 255;
    end
    exp_duty.push_back(dy[7:0]);
    exp_dist.push_back(dist_cm[6:0]);
    exp_zero.push_back(z);
  endfunction

  function void check_result(logic [7:0] dy, logic [6:0] ds, logic z);
    logic [7:0] ed;
    logic [6:0] es;
    logic ez;
    if (exp_duty.size() == 0) begin
      $display("%0t: unexpected result duty=%0d dist=%0d zero=%0d", $time, dy, ds, z);
      errors++;
      return;
    end
    ed = exp_duty.pop_front(); es = exp_dist.pop_front(); ez = exp_zero.pop_front();
    if (dy !== ed) begin
      $display("%0t: duty expected %0d actual %0d", $time, ed, dy);
      errors++;
    end
    if (ds !== es) begin
      $display("%0t: distance_cm expected %0d actual %0d", $time, es, ds);
      errors++;
    end
    if (z !== ez) begin
      $display("%0t: zero_reading expected %0d actual %0d", $time, ez, z);
      errors++;
    end
  endfunction

  function int pending();
    return exp_duty.size();
  endfunction
endclass

module tb_fuzzy_distance_pwm_controller;

  localparam int STALL_LIMIT = 5000;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full;
  logic [7:0] adc_high = 0;
  logic [7:0] adc_low = 0;
  logic pop = 0;
  logic empty;
  logic [7:0] duty;
  logic [6:0] distance_cm;
  logic zero_reading;
  logic wr_en = 0;
  logic [1:0] wr_index = 0;
  logic [8:0] wr_data = 0;

  duty_scoreboard sb = new();
  int push_idle = 0;
  int pop_idle = 0;
  int stall_cycles = 0;
  bit sending = 0;

  fuzzy_distance_pwm_controller uut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_reading(adc_high, adc_low);
      if (pop && !empty) sb.check_result(duty, distance_cm, zero_reading);
      if ((push && !full) || (pop && !empty) || (!sending && sb.pending() == 0))
        stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  always @(negedge clk) pop <= ($urandom_range(99) >= pop_idle);

  task automatic send_reading(logic [7:0] hi, logic [7:0] lo);
    while ($urandom_range(99) < push_idle) begin
      push <= 0;
      @(negedge clk);
    end
    push <= 1; adc_high <= hi; adc_low <= lo;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(fdpc_pkg::reg_idx_t idx, logic [8:0] val);
    wr_en <= 1; wr_index <= idx; wr_data <= val;
    @(negedge clk);
    wr_en <= 0;
    @(negedge clk);
    case (idx)
      fdpc_pkg::REG_SETPOINT: sb.setpoint = val[6:0];
      fdpc_pkg::REG_CLOW:     sb.c_low = val;
      fdpc_pkg::REG_CMID:     sb.c_mid = val;
      default:                sb.c_high = val;
    endcase
  endtask

  task automatic drain();
    push <= 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic random_readings(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(9);
      if (r < 6) send_reading(8'd0, 8'($urandom_range(60, 220)));
      else if (r < 8) send_reading(8'($urandom_range(1)), 8'($urandom));
      else send_reading(8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 0;
    sending = 1;
    push_idle = 18; pop_idle = 69;
    // extremes: zero reading, tiny, saturating, near rule crossovers
    send_reading(8'd0, 8'd0);
    send_reading(8'd0, 8'd1);
    send_reading(8'hff, 8'hff);
    send_reading(8'haa, 8'h55);
    send_reading(8'h55, 8'haa);
    send_reading(8'd0, 8'd2);
    send_reading(8'd0, 8'd3);
    for (int v = 70; v <= 260; v += 15) send_reading(8'(v >> 8), 8'(v));
    drain();
    write_reg(fdpc_pkg::REG_SETPOINT, 9'd10); write_reg(fdpc_pkg::REG_CLOW, 9'd0);
    write_reg(fdpc_pkg::REG_CMID, 9'd256); write_reg(fdpc_pkg::REG_CHIGH, 9'd0);
    random_readings(200);
    drain();
    write_reg(fdpc_pkg::REG_SETPOINT, 9'd80); write_reg(fdpc_pkg::REG_CLOW, 9'd511);
    write_reg(fdpc_pkg::REG_CMID, 9'd511); write_reg(fdpc_pkg::REG_CHIGH, 9'd511);
    random_readings(150);
    drain();
    push_idle = 69; pop_idle = 18;
    write_reg(fdpc_pkg::REG_SETPOINT, 9'd127); write_reg(fdpc_pkg::REG_CLOW, 9'd256);
    write_reg(fdpc_pkg::REG_CMID, 9'd0); write_reg(fdpc_pkg::REG_CHIGH, 9'd128);
    random_readings(150);
    drain();
    write_reg(fdpc_pkg::REG_SETPOINT, 9'd0); write_reg(fdpc_pkg::REG_CLOW, 9'h155);
    write_reg(fdpc_pkg::REG_CMID, 9'h0aa); write_reg(fdpc_pkg::REG_CHIGH, 9'h1ff);
    random_readings(100);
    drain();
    push_idle = 0; pop_idle = 0;
    for (int k = 0; k < 3; k++) begin
      write_reg(fdpc_pkg::REG_SETPOINT, 9'($urandom_range(10, 80)));
      write_reg(fdpc_pkg::REG_CLOW, 9'($urandom_range(0, 256)));
      write_reg(fdpc_pkg::REG_CMID, 9'($urandom_range(0, 256)));
      write_reg(fdpc_pkg::REG_CHIGH, 9'($urandom_range(0, 256)));
      random_readings(130);
      drain();
    end
    sending = 0;
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
